>>> sv/quaternion_arithmetic_unit_core_assert.svh
// Assertion macros for the quaternion unit checker
`ifndef QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_CORE_ASSERT_SVH

// Clocked assertion, disabled while in reset
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Next-cycle implication built on the one above
`define QAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  `QAU_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

>>> sv/qau_pkg.sv
// Shared types, constants and helpers of the quaternion arithmetic unit
package qau_pkg;

  localparam int DW        = 32;          // data width
  localparam int FB        = 24;          // fraction bits
  localparam int PW        = 2 * DW;      // full product
  localparam int HW        = PW + 2;      // sum of four products
  localparam int SSW       = PW + 1;      // sum of four squares
  localparam int SQ_W      = PW + 2;      // radicand, even width
  localparam int SQ_STEPS  = SQ_W / 2;    // root bits, one per stage
  localparam int RT_W      = SQ_STEPS;
  localparam int SR_W      = RT_W + 2;    // root remainder
  localparam int DIV_STEPS = DW;          // quotient bits, one per stage

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_PROD  = 3'd2;
  localparam logic [2:0] OP_SCALE = 3'd3;
  localparam logic [2:0] OP_DIV   = 3'd4;
  localparam logic [2:0] OP_CONJ  = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;
  localparam logic [2:0] OP_NORMZ = 3'd7;

  typedef logic signed [DW-1:0] data_t;
  typedef logic [DW-1:0]        udata_t;
  typedef data_t [3:0]          quat_t;

  // Hamilton product: row i, bit j set when a[j]*b[i^j] is subtracted
  localparam logic [3:0][3:0] HNEG = {4'b0100, 4'b0010, 4'b1000, 4'b1110};

  localparam data_t SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam data_t SMIN = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic [2:0] op;
    quat_t      a;
    quat_t      b;
    data_t      s;
  } in_item_t;

  typedef struct packed {
    logic [2:0] op;
    quat_t      a;
    data_t      s;
    quat_t      early;
  } side_t;

  typedef struct packed {
    logic [2:0] op;
    quat_t      early;
    udata_t     nv;
    logic       err;
    logic [3:0] neg;
  } dside_t;

  // Saturate a sign-extended wide value to the signed data range
  function automatic data_t sat_wide(input logic signed [HW-1:0] v);
    logic [HW-DW:0] top;
    top = v[HW-1:DW-1];
    if ((&top) || !(|top)) return v[DW-1:0];
    else return v[HW-1] ? SMIN : SMAX;
  endfunction

endpackage

>>> sv/qau_if.sv
// Handshake interfaces of the quaternion unit: input and result channels
interface qau_in_if import qau_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  data_t      a_w, a_x, a_y, a_z;
  data_t      b_w, b_x, b_y, b_z;
  data_t      scalar;

  modport source(output valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar,
                 input ready);
  modport sink(input valid, opcode, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, scalar,
               output ready);
endinterface

interface qau_out_if import qau_pkg::*; ();
  logic   valid;
  logic   ready;
  data_t  r_w, r_x, r_y, r_z;
  udata_t norm_value;
  logic   error_flag;

  modport source(output valid, r_w, r_x, r_y, r_z, norm_value, error_flag, input ready);
  modport sink(input valid, r_w, r_x, r_y, r_z, norm_value, error_flag, output ready);
endinterface

>>> sv/qau_front.sv
// Front stages: input register, multiplier array, product sums and saturation
module qau_front import qau_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_fire,
  input  in_item_t in_item,
  output logic     v_o,
  output side_t    side_o,
  output logic [SSW-1:0] sumsq_o
);

  logic     v1_r, v2_r, v3_r;
  in_item_t it1_r;

  logic signed [PW-1:0] prod_nxt [4][4];
  logic signed [PW-1:0] prod_r   [4][4];
  logic [PW-1:0]        sq_nxt   [4];
  logic [PW-1:0]        sq_r     [4];
  quat_t                early_nxt, early2_r;
  logic [2:0]           op2_r;
  quat_t                a2_r;
  data_t                s2_r;

  side_t          side_nxt, side3_r;
  logic [SSW-1:0] sumsq_nxt, sumsq3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_fire;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 2: products and the cheap operations
  always_comb begin
    data_t opb;
    opb = '0;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        opb = (it1_r.op == OP_SCALE) ? it1_r.s : it1_r.b[i ^ j];
        prod_nxt[i][j] = $signed(it1_r.a[j]) * $signed(opb);
      end
      sq_nxt[i] = PW'($signed(it1_r.a[i]) * $signed(it1_r.a[i]));
      case (it1_r.op)
        OP_ADD:  early_nxt[i] = sat_wide(HW'($signed(it1_r.a[i])) + HW'($signed(it1_r.b[i])));
        OP_SUB:  early_nxt[i] = sat_wide(HW'($signed(it1_r.a[i])) - HW'($signed(it1_r.b[i])));
        OP_CONJ: early_nxt[i] = (i == 0) ? it1_r.a[i]
                                         : sat_wide(-HW'($signed(it1_r.a[i])));
        default: early_nxt[i] = '0;
      endcase
    end
  end

  // stage 3: sum products, drop fraction bits, saturate
  always_comb begin
    logic signed [HW-1:0] ham;
    logic signed [HW-1:0] scl;
    ham = '0;
    scl = '0;
    side_nxt.op = op2_r;
    side_nxt.a  = a2_r;
    side_nxt.s  = s2_r;
    for (int i = 0; i < 4; i++) begin
      ham = '0;
      for (int j = 0; j < 4; j++) begin
        ham = HNEG[i][j] ? ham - HW'(prod_r[i][j]) : ham + HW'(prod_r[i][j]);
      end
      scl = HW'(prod_r[i][i]);
      case (op2_r)
        OP_PROD:  side_nxt.early[i] = sat_wide(ham >>> FB);
        OP_SCALE: side_nxt.early[i] = sat_wide(scl >>> FB);
        default:  side_nxt.early[i] = early2_r[i];
      endcase
    end
    sumsq_nxt = SSW'(sq_r[0]) + SSW'(sq_r[1]) + SSW'(sq_r[2]) + SSW'(sq_r[3]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1_r    <= in_item;
      prod_r   <= prod_nxt;
      sq_r     <= sq_nxt;
      early2_r <= early_nxt;
      op2_r    <= it1_r.op;
      a2_r     <= it1_r.a;
      s2_r     <= it1_r.s;
      side3_r  <= side_nxt;
      sumsq3_r <= sumsq_nxt;
    end
  end

  assign v_o     = v3_r;
  assign side_o  = side3_r;
  assign sumsq_o = sumsq3_r;

endmodule

>>> sv/qau_sqrt.sv
// Pipelined integer square root, one root bit per stage
module qau_sqrt import qau_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] rad,
  output logic [RT_W-1:0] root
);

  logic [SQ_W-1:0] x_r    [SQ_STEPS];
  logic [SR_W-1:0] rem_r  [SQ_STEPS];
  logic [RT_W-1:0] root_r [SQ_STEPS];

  logic [SQ_W-1:0] x_nxt    [SQ_STEPS];
  logic [SR_W-1:0] rem_nxt  [SQ_STEPS];
  logic [RT_W-1:0] root_nxt [SQ_STEPS];

  always_comb begin
    logic [SQ_W-1:0] x_in;
    logic [SR_W-1:0] rem_in, rem_sh, trial;
    logic [RT_W-1:0] root_in;
    logic            ge;
    for (int k = 0; k < SQ_STEPS; k++) begin
      x_in    = (k == 0) ? rad : x_r[(k == 0) ? 0 : k - 1];
      rem_in  = (k == 0) ? '0  : rem_r[(k == 0) ? 0 : k - 1];
      root_in = (k == 0) ? '0  : root_r[(k == 0) ? 0 : k - 1];
      rem_sh  = {rem_in[SR_W-3:0], x_in[SQ_W-1:SQ_W-2]};
      trial   = {root_in, 2'b01};
      ge      = (rem_sh >= trial);
      rem_nxt[k]  = ge ? rem_sh - trial : rem_sh;
      root_nxt[k] = {root_in[RT_W-2:0], ge};
      x_nxt[k]    = {x_in[SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= x_nxt;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign root = root_r[SQ_STEPS-1];

endmodule

>>> sv/qau_div.sv
// Pipelined restoring divider: (mag << FB) / dvs, one quotient bit per stage
module qau_div import qau_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  udata_t mag,
  input  udata_t dvs,
  output udata_t quo,
  output logic   ovf
);

  logic [DW:0] rem_r [DIV_STEPS];
  udata_t      n_r   [DIV_STEPS];
  udata_t      q_r   [DIV_STEPS];
  udata_t      d_r   [DIV_STEPS];
  logic        ovf_r [DIV_STEPS];

  logic [DW:0] rem_nxt [DIV_STEPS];
  udata_t      n_nxt   [DIV_STEPS];
  udata_t      q_nxt   [DIV_STEPS];
  udata_t      d_nxt   [DIV_STEPS];
  logic        ovf_nxt [DIV_STEPS];

  always_comb begin
    udata_t      hi, n_in, q_in, d_in;
    logic [DW:0] rem_in, rs;
    logic        ge, ovf_in;
    hi = mag >> (DW - FB);
    for (int k = 0; k < DIV_STEPS; k++) begin
      n_in   = (k == 0) ? (mag << FB) : n_r[(k == 0) ? 0 : k - 1];
      rem_in = (k == 0) ? {1'b0, hi}  : rem_r[(k == 0) ? 0 : k - 1];
      q_in   = (k == 0) ? '0          : q_r[(k == 0) ? 0 : k - 1];
      d_in   = (k == 0) ? dvs         : d_r[(k == 0) ? 0 : k - 1];
      ovf_in = (k == 0) ? (hi >= dvs) : ovf_r[(k == 0) ? 0 : k - 1];
      rs = {rem_in[DW-1:0], n_in[DW-1]};
      ge = (rs >= {1'b0, d_in});
      rem_nxt[k] = ge ? rs - {1'b0, d_in} : rs;
      n_nxt[k]   = n_in << 1;
      q_nxt[k]   = {q_in[DW-2:0], ge};
      d_nxt[k]   = d_in;
      ovf_nxt[k] = ovf_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      n_r   <= n_nxt;
      q_r   <= q_nxt;
      d_r   <= d_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign quo = q_r[DIV_STEPS-1];
  assign ovf = ovf_r[DIV_STEPS-1];

endmodule

>>> sv/quaternion_arithmetic_unit_core.sv
// Top level of the quaternion arithmetic unit: pipeline and result register
//
//   channel   dir   handshake        payload
//   in_if     in    valid / ready    opcode, a_w..a_z, b_w..b_z, scalar
//   out_if    out   valid / ready    r_w..r_z, norm_value, error_flag
//
// One item per cycle while the output is not stalled; the pipeline holds 3 front
// stages, 33 square-root stages, 32 divider stages and the result register. The
// root and the divider run for every item, so every opcode has the same latency.
// Reset (rst_n low, synchronous) clears the valid bits; payload is left.
// A stall at the output freezes the whole pipeline in place.
module quaternion_arithmetic_unit_core import qau_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  qau_in_if.sink    in_if,
  qau_out_if.source out_if
);

  // global advance: the result register is empty or being drained
  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_if.ready;
  assign in_if.ready = en;

  in_item_t in_item;
  assign in_item.op   = in_if.opcode;
  assign in_item.a    = {in_if.a_z, in_if.a_y, in_if.a_x, in_if.a_w};
  assign in_item.b    = {in_if.b_z, in_if.b_y, in_if.b_x, in_if.b_w};
  assign in_item.s    = in_if.scalar;

  // front: products, sums, early results
  logic           v3;
  side_t          side3;
  logic [SSW-1:0] sumsq3;

  qau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_fire (in_if.valid && en),
    .in_item (in_item),
    .v_o     (v3),
    .side_o  (side3),
    .sumsq_o (sumsq3)
  );

  // square root of the sum of squares
  logic [RT_W-1:0] root;

  qau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (SQ_W'(sumsq3)),
    .root (root)
  );

  // side data travelling alongside the root stages
  logic [SQ_STEPS-1:0] vq_r;
  side_t               side_q_r [SQ_STEPS];
  side_t               sq_last;
  assign sq_last = side_q_r[SQ_STEPS-1];

  // divider set-up: norm saturation, divisor choice, error and signs
  udata_t nv, dvs;
  dside_t dside_nxt;
  udata_t mag [4];

  always_comb begin
    logic is_div;
    is_div = (sq_last.op == OP_DIV);
    nv  = root[RT_W-1] ? '1 : root[DW-1:0];
    dvs = is_div ? udata_t'(sq_last.s[DW-1] ? -sq_last.s : sq_last.s) : nv;
    dside_nxt.op    = sq_last.op;
    dside_nxt.early = sq_last.early;
    dside_nxt.nv    = nv;
    dside_nxt.err   = (is_div && (sq_last.s == '0)) ||
                      ((sq_last.op == OP_NORMZ) && (nv == '0));
    for (int i = 0; i < 4; i++) begin
      mag[i] = udata_t'(sq_last.a[i][DW-1] ? -sq_last.a[i] : sq_last.a[i]);
      dside_nxt.neg[i] = sq_last.a[i][DW-1] ^ (is_div && sq_last.s[DW-1]);
    end
  end

  udata_t quo [4];
  logic   ovf [4];

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_div u_div (
      .clk (clk),
      .en  (en),
      .mag (mag[g]),
      .dvs (dvs),
      .quo (quo[g]),
      .ovf (ovf[g])
    );
  end

  logic [DIV_STEPS-1:0] vd_r;
  dside_t               side_d_r [DIV_STEPS];
  dside_t               dl;
  assign dl = side_d_r[DIV_STEPS-1];

  // result selection: quotients get their sign and saturate here
  quat_t rq_nxt;
  always_comb begin
    data_t dq;
    dq = '0;
    for (int i = 0; i < 4; i++) begin
      if (!dl.neg[i]) begin
        dq = (ovf[i] || quo[i][DW-1]) ? SMAX : data_t'(quo[i]);
      end else begin
        dq = (ovf[i] || (quo[i][DW-1] && (|quo[i][DW-2:0]))) ? SMIN
                                                             : data_t'(-quo[i]);
      end
      if (dl.err) rq_nxt[i] = '0;
      else if ((dl.op == OP_DIV) || (dl.op == OP_NORMZ)) rq_nxt[i] = dq;
      else rq_nxt[i] = dl.early[i];
    end
  end

  quat_t  rq_r;
  udata_t nv_r;
  logic   err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r        <= '0;
      vd_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vq_r        <= {vq_r[SQ_STEPS-2:0], v3};
      vd_r        <= {vd_r[DIV_STEPS-2:0], vq_r[SQ_STEPS-1]};
      out_valid_r <= vd_r[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q_r[0] <= side3;
      for (int k = 1; k < SQ_STEPS; k++) side_q_r[k] <= side_q_r[k-1];
      side_d_r[0] <= dside_nxt;
      for (int k = 1; k < DIV_STEPS; k++) side_d_r[k] <= side_d_r[k-1];
      rq_r  <= rq_nxt;
      nv_r  <= dl.nv;
      err_r <= dl.err;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.r_w        = rq_r[0];
  assign out_if.r_x        = rq_r[1];
  assign out_if.r_y        = rq_r[2];
  assign out_if.r_z        = rq_r[3];
  assign out_if.norm_value = nv_r;
  assign out_if.error_flag = err_r;

endmodule

>>> sv/qau_checker.sv
// Port-level checker for the quaternion unit, bound to the top level
`include "quaternion_arithmetic_unit_core_assert.svh"

module qau_checker import qau_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_ready,
  input logic   out_valid,
  input logic   out_ready,
  input data_t  r_w,
  input data_t  r_x,
  input data_t  r_y,
  input data_t  r_z,
  input udata_t norm_value,
  input logic   error_flag
);

  `QAU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `QAU_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(r_w) && $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(norm_value) && $stable(error_flag), "result changed while stalled")
  `QAU_ASSERT(a_err_zero, out_valid && error_flag |-> r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0, "error item with non-zero quaternion")
  `QAU_ASSERT(a_ready_free, !out_valid |-> in_ready, "input blocked with empty output")

endmodule

bind quaternion_arithmetic_unit_core qau_checker u_qau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .r_w        (out_if.r_w),
  .r_x        (out_if.r_x),
  .r_y        (out_if.r_y),
  .r_z        (out_if.r_z),
  .norm_value (out_if.norm_value),
  .error_flag (out_if.error_flag)
);
